>>> design/aip_pkg.sv
`default_nettype none

package aip_pkg;

   // Largest alphabet the digit lookup supports; the two alphabet registers hold 16 bytes.
   localparam int unsigned MAX_RADIX_CHARS = 16;
   localparam int unsigned ALPHA_BYTES     = 16;

   localparam logic [7:0] CH_NUL   = 8'd0;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;

   localparam logic [63:0] DIGITS_LOW_RESET  = 64'h3736_3534_3332_3130;
   localparam logic [63:0] DIGITS_HIGH_RESET = 64'h0000_0000_0000_3938;
   localparam logic [4:0]  RADIX_RESET       = 5'd10;

   typedef enum logic [1:0] {
      PH_SPACE  = 2'd0,
      PH_SIGN   = 2'd1,
      PH_DIGITS = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK           = 2'd0,
      ST_BAD_ALPHABET = 2'd1,
      ST_RANGE        = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_DIGITS_LOW   = 2'd0,
      CSR_DIGITS_HIGH  = 2'd1,
      CSR_RADIX_LENGTH = 2'd2
   } csr_index_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_sign(input logic [7:0] c);
      return (c == CH_PLUS) || (c == CH_MINUS);
   endfunction

endpackage

`default_nettype wire

>>> design/aip_if.sv
`default_nettype none

interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink (input valid, input character, input last, output ready);
endinterface

interface aip_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> design/ascii_integer_parse_in_base.sv
`default_nettype none

// Converts a byte string, one character per transfer, into a signed 32-bit integer in a
// programmable alphabet of up to 16 digit characters (digit value is the position in the
// alphabet). Leading whitespace is skipped, then any run of plus and minus signs (an odd
// number of minus signs negates), then digits until the first non-digit byte. The transfer
// marked last produces one result: the value and a status (0 ok, 1 invalid alphabet,
// 2 out of range); the value is zero on any error. The alphabet compare and the
// multiply-add by the radix sit between the parse registers and the result register,
// so a character is accepted every cycle while the result register is empty or being
// drained, and the registered result shows in the cycle after its last character.
// Alphabet registers should be written between strings.
module ascii_integer_parse_in_base (
   input  logic        clock,
   input  logic        reset,
   aip_req_if.sink     req_bus,
   aip_rsp_if.source   rsp_bus,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   logic [63:0] digits_low_ff, digits_low_in;
   logic [63:0] digits_high_ff, digits_high_in;
   logic [4:0]  radix_ff, radix_in;

   aip_pkg::phase_type phase_ff, phase_in;
   logic               parity_ff, parity_in;
   logic [31:0]        magnitude_ff, magnitude_in;
   logic               range_ff, range_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] value_ff, value_in;
   logic [1:0]         status_ff, status_in;

   logic [7:0]  alpha [aip_pkg::ALPHA_BYTES];
   logic [aip_pkg::ALPHA_BYTES-1:0] in_use;
   logic [aip_pkg::ALPHA_BYTES-1:0] bad_char;
   logic [4:0]  active_len;
   logic        len_ok;
   logic        alphabet_ok;
   logic        hit;
   logic [3:0]  digit;

   logic               accept;
   logic               req_ready;
   aip_pkg::phase_type phase_a, phase_b;
   logic               sign_step, digit_step;
   logic [36:0]        acc;
   logic               parity_upd, range_upd;
   logic [31:0]        magnitude_upd;

   // Configuration registers.
   always_comb begin
      digits_low_in  = digits_low_ff;
      digits_high_in = digits_high_ff;
      radix_in       = radix_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            aip_pkg::CSR_DIGITS_LOW:   digits_low_in  = csr_write_data;
            aip_pkg::CSR_DIGITS_HIGH:  digits_high_in = csr_write_data;
            aip_pkg::CSR_RADIX_LENGTH: radix_in       = csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digits_low_ff  <= aip_pkg::DIGITS_LOW_RESET;
         digits_high_ff <= aip_pkg::DIGITS_HIGH_RESET;
         radix_ff       <= aip_pkg::RADIX_RESET;
      end else begin
         digits_low_ff  <= digits_low_in;
         digits_high_ff <= digits_high_in;
         radix_ff       <= radix_in;
      end
   end

   // Alphabet decode and validity.
   assign active_len = (radix_ff > 5'(aip_pkg::MAX_RADIX_CHARS)) ?
                       5'(aip_pkg::MAX_RADIX_CHARS) : radix_ff;
   assign len_ok = (radix_ff >= 5'd2) && (radix_ff <= 5'(aip_pkg::MAX_RADIX_CHARS));

   always_comb begin
      for (int i = 0; i < aip_pkg::ALPHA_BYTES; i++) begin
         if (i < 8) begin
            alpha[i] = digits_low_ff[8*i +: 8];
         end else begin
            alpha[i] = digits_high_ff[8*(i-8) +: 8];
         end
         in_use[i] = 5'(i) < active_len;
      end
   end

   always_comb begin
      for (int i = 0; i < aip_pkg::ALPHA_BYTES; i++) begin
         bad_char[i] = in_use[i] && ((alpha[i] == aip_pkg::CH_NUL) ||
                       aip_pkg::is_space(alpha[i]) || aip_pkg::is_sign(alpha[i]));
         // A repeat of any earlier character makes the alphabet ambiguous.
         for (int j = 0; j < i; j++) begin
            if (in_use[i] && (alpha[i] == alpha[j])) begin
               bad_char[i] = 1'b1;
            end
         end
      end
   end

   assign alphabet_ok = len_ok && (bad_char == '0);

   // The lowest matching position wins, so scan from the top down.
   always_comb begin
      hit   = 1'b0;
      digit = '0;
      for (int i = aip_pkg::ALPHA_BYTES - 1; i >= 0; i--) begin
         if (in_use[i] && (alpha[i] == req_bus.character)) begin
            hit   = 1'b1;
            digit = 4'(i);
         end
      end
   end

   // Handshake: the result register frees up in the same cycle it is drained.
   assign req_ready     = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = req_ready;
   assign accept        = req_bus.valid && req_ready;

   // Phase walk for the current character.
   always_comb begin
      phase_a = phase_ff;
      if ((phase_ff == aip_pkg::PH_SPACE) && !aip_pkg::is_space(req_bus.character)) begin
         phase_a = aip_pkg::PH_SIGN;
      end
      phase_b = phase_a;
      if ((phase_a == aip_pkg::PH_SIGN) && !aip_pkg::is_sign(req_bus.character)) begin
         phase_b = aip_pkg::PH_DIGITS;
      end
      sign_step  = (phase_a == aip_pkg::PH_SIGN) && aip_pkg::is_sign(req_bus.character);
      digit_step = (phase_b == aip_pkg::PH_DIGITS) && hit;
   end

   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_bus.last) begin
            phase_in = aip_pkg::PH_SPACE;
         end else if ((phase_b == aip_pkg::PH_DIGITS) && !hit) begin
            phase_in = aip_pkg::PH_DONE;
         end else begin
            phase_in = phase_b;
         end
      end
   end

   // Accumulator and result. The magnitude never exceeds 2^31, so 37 bits hold the sum.
   always_comb begin
      acc = 37'(magnitude_ff) * 37'(active_len) + 37'(digit);
      parity_upd    = parity_ff ^ (sign_step && (req_bus.character == aip_pkg::CH_MINUS));
      range_upd     = range_ff;
      magnitude_upd = magnitude_ff;
      if (digit_step && !range_ff) begin
         if (acc > 37'h0_8000_0000) begin
            range_upd = 1'b1;
         end else begin
            magnitude_upd = acc[31:0];
         end
      end

      value_in  = value_ff;
      status_in = status_ff;
      if (accept && req_bus.last) begin
         value_in = '0;
         if (!alphabet_ok) begin
            status_in = aip_pkg::ST_BAD_ALPHABET;
         end else if (range_upd || (!parity_upd && magnitude_upd[31])) begin
            status_in = aip_pkg::ST_RANGE;
         end else begin
            status_in = aip_pkg::ST_OK;
            value_in  = parity_upd ? -$signed(magnitude_upd) : $signed(magnitude_upd);
         end
      end

      parity_in    = parity_ff;
      magnitude_in = magnitude_ff;
      range_in     = range_ff;
      if (accept) begin
         parity_in    = req_bus.last ? 1'b0 : parity_upd;
         magnitude_in = req_bus.last ? '0 : magnitude_upd;
         range_in     = req_bus.last ? 1'b0 : range_upd;
      end

      if (accept && req_bus.last) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= aip_pkg::PH_SPACE;
         parity_ff    <= 1'b0;
         magnitude_ff <= '0;
         range_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         parity_ff    <= parity_in;
         magnitude_ff <= magnitude_in;
         range_ff     <= range_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      status_ff <= status_in;
   end

   assign rsp_bus.valid  = rsp_valid_ff;
   assign rsp_bus.value  = value_ff;
   assign rsp_bus.status = status_ff;

endmodule

`default_nettype wire

>>> design/aip_checker.sv
`default_nettype none

module aip_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_last,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_value,
   input logic [1:0]         rsp_status
);

   // A pending result stays offered until it is transferred.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // A new result only follows a transfer of a last character.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last))
      else $error("result without a last character");

   // Any error status carries a zero value, and status three never appears.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == aip_pkg::ST_BAD_ALPHABET ||
                    rsp_status == aip_pkg::ST_RANGE) |-> rsp_value == 32'sd0)
      else $error("nonzero value with error status");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status != 2'd3)
      else $error("undefined status code");

   // With the result register empty the input side must be open.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

endmodule

bind ascii_integer_parse_in_base aip_checker u_aip_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .req_last   (req_bus.last),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_status (rsp_bus.status)
);

`default_nettype wire
